>>> hw/rtl/ihc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 header check package
// Shared item types, codes and constants of the IPv4 header check block.
// ----------------------------------------------------------------------------
package ihc_pkg;

    localparam int IP_HDR_BYTES = 20;
    localparam int FIFO_DEPTH   = 2;

    localparam logic [7:0]  VER_IHL_IPV4  = 8'h45;
    localparam logic [7:0]  FLAG_DF       = 8'h40;
    localparam logic [15:0] CSUM_GOOD     = 16'hFFFF;
    localparam logic [15:0] LEN_MAX       = 16'hFFFF;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [2:0] DROP_NONE     = 3'd0;
    localparam logic [2:0] DROP_HEADER   = 3'd1;
    localparam logic [2:0] DROP_LENGTH   = 3'd2;
    localparam logic [2:0] DROP_CHECKSUM = 3'd3;
    localparam logic [2:0] DROP_FRAGMENT = 3'd4;
    localparam logic [2:0] DROP_PROTOCOL = 3'd5;

    localparam logic [1:0] CLASS_ICMP  = 2'd0;
    localparam logic [1:0] CLASS_UDP   = 2'd1;
    localparam logic [1:0] CLASS_TCP   = 2'd2;
    localparam logic [1:0] CLASS_OTHER = 2'd3;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  drop_reason;
        logic [1:0]  proto_class;
        logic [7:0]  protocol_number;
        logic [15:0] ip_total_length;
        logic [15:0] received_length;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [31:0] icmp_count;
    } out_item_t;

    typedef struct packed {
        logic [15:0] rx_length;
        logic [7:0]  ver_ihl;
        logic [15:0] total_length;
        logic [7:0]  flags_hi;
        logic [7:0]  frag_lo;
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic        csum_ok;
    } summary_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

>>> hw/rtl/ihc_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 header parser
// Skips the MAC header, captures the IP header, sums its words and emits a
// frame summary on the last byte.
// ----------------------------------------------------------------------------
module ihc_parse #(
    parameter int MAC_HEADER_BYTES = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ihc_pkg::in_item_t  request,
    input  logic               stall,
    output logic               accept,
    output logic               sum_valid,
    output ihc_pkg::summary_t  summary
);

    localparam int MAC_W = $clog2(MAC_HEADER_BYTES + 2);

    logic [MAC_W-1:0] mac_cnt_reg, mac_cnt_next;
    logic [15:0]      pos_reg, pos_next;
    logic [15:0]      csum_reg, csum_next;
    logic [7:0]       prev_reg, prev_next;
    logic [7:0]       hdr_reg  [ihc_pkg::IP_HDR_BYTES];
    logic [7:0]       hdr_next [ihc_pkg::IP_HDR_BYTES];
    logic             ip_byte;
    logic [16:0]      sum_wide;
    logic [15:0]      sum_fold;
    logic [15:0]      pos_inc;

    assign accept  = push && !stall;
    assign ip_byte = (mac_cnt_reg == MAC_W'(MAC_HEADER_BYTES));
    assign pos_inc = (pos_reg == ihc_pkg::LEN_MAX) ? pos_reg : pos_reg + 16'd1;
    assign sum_wide = {1'b0, csum_reg} + {1'b0, prev_reg, request.frame_byte};
    assign sum_fold = sum_wide[15:0] + {15'd0, sum_wide[16]};

    always_comb
    begin
        mac_cnt_next = mac_cnt_reg;
        pos_next     = pos_reg;
        csum_next    = csum_reg;
        prev_next    = prev_reg;
        for (int i = 0; i < ihc_pkg::IP_HDR_BYTES; i++)
        begin
            hdr_next[i] = hdr_reg[i];
        end
        if (!ip_byte)
        begin
            mac_cnt_next = mac_cnt_reg + MAC_W'(1);
        end
        else
        begin
            prev_next = request.frame_byte;
            pos_next  = pos_inc;
            for (int i = 0; i < ihc_pkg::IP_HDR_BYTES; i++)
            begin
                if (pos_reg == 16'(i))
                begin
                    hdr_next[i] = request.frame_byte;
                end
            end
            if (pos_reg < 16'(ihc_pkg::IP_HDR_BYTES) && pos_reg[0])
            begin
                csum_next = sum_fold;
            end
        end
    end

    always_comb
    begin
        summary.rx_length    = pos_next;
        summary.ver_ihl      = hdr_next[0];
        summary.total_length = {hdr_next[2], hdr_next[3]};
        summary.flags_hi     = hdr_next[6];
        summary.frag_lo      = hdr_next[7];
        summary.protocol     = hdr_next[9];
        summary.src_addr     = {hdr_next[12], hdr_next[13], hdr_next[14], hdr_next[15]};
        summary.dst_addr     = {hdr_next[16], hdr_next[17], hdr_next[18], hdr_next[19]};
        summary.csum_ok      = (csum_next == ihc_pkg::CSUM_GOOD);
    end

    assign sum_valid = accept && request.last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_cnt_reg <= '0;
            pos_reg     <= '0;
            csum_reg    <= '0;
        end
        else if (accept)
        begin
            if (request.last_byte)
            begin
                mac_cnt_reg <= '0;
                pos_reg     <= '0;
                csum_reg    <= '0;
            end
            else
            begin
                mac_cnt_reg <= mac_cnt_next;
                pos_reg     <= pos_next;
                csum_reg    <= csum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev_reg <= prev_next;
            for (int i = 0; i < ihc_pkg::IP_HDR_BYTES; i++)
            begin
                hdr_reg[i] <= hdr_next[i];
            end
        end
    end

endmodule

>>> hw/rtl/ihc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame summary queue
// Short queue between the parser and the classifier.
// ----------------------------------------------------------------------------
module ihc_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  ihc_pkg::summary_t      wr_data,
    input  logic                   rd_en,
    output ihc_pkg::summary_t      rd_data,
    output ihc_pkg::fifo_status_t  status
);

    localparam int PTR_W = $clog2(ihc_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(ihc_pkg::FIFO_DEPTH + 1);

    ihc_pkg::summary_t mem [ihc_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_wr, do_rd;

    assign status.full  = (count_reg == CNT_W'(ihc_pkg::FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_data      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(ihc_pkg::FIFO_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(ihc_pkg::FIFO_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

>>> hw/rtl/ihc_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 verdict and classifier
// Applies the header checks to a frame summary, classes the protocol, counts
// accepted ICMP packets and holds the result for transfer.
// ----------------------------------------------------------------------------
module ihc_classify (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sum_avail,
    input  ihc_pkg::summary_t  summary,
    output logic               sum_take,
    input  logic               pop,
    output logic               empty,
    output ihc_pkg::out_item_t result
);

    logic                res_valid_reg;
    ihc_pkg::out_item_t  res_reg, res_next;
    logic [31:0]         icmp_reg;
    logic                icmp_hit;

    always_comb
    begin
        res_next                 = '0;
        res_next.proto_class     = ihc_pkg::CLASS_OTHER;
        res_next.received_length = summary.rx_length;
        icmp_hit                 = 1'b0;
        if (!(summary.rx_length > 16'(ihc_pkg::IP_HDR_BYTES) &&
              summary.ver_ihl == ihc_pkg::VER_IHL_IPV4))
        begin
            res_next.drop_reason = ihc_pkg::DROP_HEADER;
        end
        else if (summary.total_length > summary.rx_length)
        begin
            res_next.drop_reason = ihc_pkg::DROP_LENGTH;
        end
        else
        begin
            res_next.ip_total_length = summary.total_length;
            if (!summary.csum_ok)
            begin
                res_next.drop_reason = ihc_pkg::DROP_CHECKSUM;
            end
            else if ((summary.flags_hi & ~ihc_pkg::FLAG_DF) != 8'd0 ||
                     summary.frag_lo != 8'd0)
            begin
                res_next.drop_reason = ihc_pkg::DROP_FRAGMENT;
            end
            else
            begin
                res_next.protocol_number = summary.protocol;
                res_next.source_address  = summary.src_addr;
                res_next.dest_address    = summary.dst_addr;
                res_next.accepted        = 1'b1;
                case (summary.protocol)
                    ihc_pkg::PROTO_ICMP:
                    begin
                        res_next.proto_class = ihc_pkg::CLASS_ICMP;
                        icmp_hit             = 1'b1;
                    end
                    ihc_pkg::PROTO_UDP:  res_next.proto_class = ihc_pkg::CLASS_UDP;
                    ihc_pkg::PROTO_TCP:  res_next.proto_class = ihc_pkg::CLASS_TCP;
                    default:
                    begin
                        res_next.accepted    = 1'b0;
                        res_next.drop_reason = ihc_pkg::DROP_PROTOCOL;
                    end
                endcase
            end
        end
        res_next.icmp_count = icmp_reg + {31'd0, icmp_hit};
    end

    assign sum_take = sum_avail && (!res_valid_reg || pop);
    assign empty    = !res_valid_reg;
    assign result   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            icmp_reg      <= '0;
        end
        else
        begin
            if (sum_take)
            begin
                res_valid_reg <= 1'b1;
                icmp_reg      <= res_next.icmp_count;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_take)
        begin
            res_reg <= res_next;
        end
    end

endmodule

>>> hw/rtl/ipv4_header_check_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 header check and classifier
// Takes one frame byte per transfer and, on the last byte of each frame,
// delivers one verdict with the header fields and the ICMP packet count.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while full is low; the parser updates its
// counters and the running header sum as each byte is taken, and full is high
// only while both entries of the summary queue are waiting.
// A verdict is written into the summary queue on the transfer of the last byte
// and moves into the result register when that register is free or popped.
// Reset: asynchronous, active low; clears counters, sum, queue and result valid.
// ----------------------------------------------------------------------------
module ipv4_header_check_classify #(
    parameter int MAC_HEADER_BYTES = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  ihc_pkg::in_item_t  request,
    output logic               empty,
    input  logic               pop,
    output ihc_pkg::out_item_t result
);

    ihc_pkg::fifo_status_t fifo_stat;
    ihc_pkg::summary_t     wr_sum, rd_sum;
    logic                  accept, sum_valid, sum_take;

    assign full = fifo_stat.full;

    ihc_parse #(
        .MAC_HEADER_BYTES(MAC_HEADER_BYTES)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .request   (request),
        .stall     (fifo_stat.full),
        .accept    (accept),
        .sum_valid (sum_valid),
        .summary   (wr_sum)
    );

    ihc_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (sum_valid),
        .wr_data (wr_sum),
        .rd_en   (sum_take),
        .rd_data (rd_sum),
        .status  (fifo_stat)
    );

    ihc_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum_avail (!fifo_stat.empty),
        .summary   (rd_sum),
        .sum_take  (sum_take),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.accepted) |->
            (result.drop_reason == ihc_pkg::DROP_NONE &&
             result.proto_class != ihc_pkg::CLASS_OTHER))
        else $error("accepted result carries a drop code or unknown class");

    a_drop_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.drop_reason != ihc_pkg::DROP_NONE &&
         result.drop_reason != ihc_pkg::DROP_PROTOCOL) |->
            (!result.accepted && result.proto_class == ihc_pkg::CLASS_OTHER &&
             result.protocol_number == 8'd0 && result.source_address == 32'd0 &&
             result.dest_address == 32'd0))
        else $error("header drop reports header data");

    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_stat.full && fifo_stat.empty) && !(accept && fifo_stat.full))
        else $error("summary queue status inconsistent");

endmodule

>>> dv/tb_ipv4_header_check_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 header check and classifier testbench
// Streams Ethernet frames byte by byte into the block and checks every verdict
// against an in-bench model of the parser, checksum and classification rules.
// Directed frames cover the boundaries and each drop reason. Random frames,
// mostly well-formed, follow with sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb_ipv4_header_check_classify;

    localparam int MAC_BYTES = 14;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               pop = 1'b0;
    ihc_pkg::in_item_t  request = '0;
    logic               full;
    logic               empty;
    ihc_pkg::out_item_t result;

    ihc_pkg::in_item_t  pend_q[$];
    ihc_pkg::out_item_t verdict_q[$];
    logic [7:0]         frame_buf[$];

    int accepted_count = 0;
    int total_items = 0;
    int phase_a = 0;
    int phase_b = 0;
    int fail_count = 0;

    int          mac_pos = 0;
    logic [15:0] ip_pos = '0;
    logic [16:0] hdr_sum = '0;
    logic [7:0]  hdr_mem [ihc_pkg::IP_HDR_BYTES];
    logic [31:0] icmp_total = '0;

    ipv4_header_check_classify #(
        .MAC_HEADER_BYTES(MAC_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .request(request),
        .empty(empty),
        .pop(pop),
        .result(result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int traffic_phase();
        if (accepted_count < phase_a)
            return 0;
        else if (accepted_count < phase_b)
            return 1;
        return 2;
    endfunction

    task automatic classify_byte(input ihc_pkg::in_item_t it);
        ihc_pkg::out_item_t v;
        logic [15:0]        tot;
        logic [4:0]         hidx;
        v = '0;
        hidx = 5'(ip_pos);
        if (mac_pos < MAC_BYTES)
        begin
            mac_pos++;
        end
        else
        begin
            if (ip_pos < ihc_pkg::IP_HDR_BYTES)
            begin
                hdr_mem[hidx] = it.frame_byte;
                if (ip_pos[0])
                begin
                    hdr_sum = hdr_sum + {hdr_mem[hidx - 5'd1], it.frame_byte};
                    hdr_sum = {1'b0, hdr_sum[15:0]} + hdr_sum[16];
                end
            end
            if (ip_pos != ihc_pkg::LEN_MAX)
                ip_pos++;
        end
        if (it.last_byte)
        begin
            v.drop_reason = ihc_pkg::DROP_NONE;
            v.proto_class = ihc_pkg::CLASS_OTHER;
            v.received_length = ip_pos;
            if (!(ip_pos > ihc_pkg::IP_HDR_BYTES && hdr_mem[0] == ihc_pkg::VER_IHL_IPV4))
            begin
                v.drop_reason = ihc_pkg::DROP_HEADER;
            end
            else
            begin
                tot = {hdr_mem[2], hdr_mem[3]};
                if (tot > ip_pos)
                begin
                    v.drop_reason = ihc_pkg::DROP_LENGTH;
                end
                else
                begin
                    v.ip_total_length = tot;
                    if (hdr_sum != {1'b0, ihc_pkg::CSUM_GOOD})
                    begin
                        v.drop_reason = ihc_pkg::DROP_CHECKSUM;
                    end
                    else if ((hdr_mem[6] & ~ihc_pkg::FLAG_DF) != 8'd0 ||
                             hdr_mem[7] != 8'd0)
                    begin
                        v.drop_reason = ihc_pkg::DROP_FRAGMENT;
                    end
                    else
                    begin
                        v.protocol_number = hdr_mem[9];
                        v.source_address = {hdr_mem[12], hdr_mem[13], hdr_mem[14], hdr_mem[15]};
                        v.dest_address = {hdr_mem[16], hdr_mem[17], hdr_mem[18], hdr_mem[19]};
                        if (hdr_mem[9] == ihc_pkg::PROTO_ICMP)
                        begin
                            v.proto_class = ihc_pkg::CLASS_ICMP;
                            v.accepted = 1'b1;
                            icmp_total++;
                        end
                        else if (hdr_mem[9] == ihc_pkg::PROTO_UDP)
                        begin
                            v.proto_class = ihc_pkg::CLASS_UDP;
                            v.accepted = 1'b1;
                        end
                        else if (hdr_mem[9] == ihc_pkg::PROTO_TCP)
                        begin
                            v.proto_class = ihc_pkg::CLASS_TCP;
                            v.accepted = 1'b1;
                        end
                        else
                        begin
                            v.drop_reason = ihc_pkg::DROP_PROTOCOL;
                        end
                    end
                end
            end
            v.icmp_count = icmp_total;
            verdict_q.push_back(v);
            mac_pos = 0;
            ip_pos = '0;
            hdr_sum = '0;
        end
    endtask

    task automatic emit_frame();
        ihc_pkg::in_item_t it;
        for (int i = 0; i < frame_buf.size(); i++)
        begin
            it.frame_byte = frame_buf[i];
            it.last_byte = (i == frame_buf.size() - 1);
            pend_q.push_back(it);
        end
        frame_buf.delete();
    endtask

    task automatic build_frame(input logic [7:0] ver, input logic [7:0] proto,
                               input logic [7:0] flg, input logic [7:0] frg,
                               input int pay_len, input int tot_len, input bit bad_csum,
                               input logic [31:0] src, input logic [31:0] dst);
        logic [7:0]  hdr [ihc_pkg::IP_HDR_BYTES];
        logic [31:0] acc;
        logic [15:0] tot16;
        int          k;
        for (int i = 0; i < MAC_BYTES; i++)
            frame_buf.push_back(8'($urandom));
        tot16 = 16'(tot_len);
        hdr[0] = ver;
        hdr[1] = 8'($urandom);
        hdr[2] = tot16[15:8];
        hdr[3] = tot16[7:0];
        hdr[4] = 8'($urandom);
        hdr[5] = 8'($urandom);
        hdr[6] = flg;
        hdr[7] = frg;
        hdr[8] = 8'($urandom);
        hdr[9] = proto;
        hdr[10] = 8'd0;
        hdr[11] = 8'd0;
        {hdr[12], hdr[13], hdr[14], hdr[15]} = src;
        {hdr[16], hdr[17], hdr[18], hdr[19]} = dst;
        acc = '0;
        for (int i = 0; i < ihc_pkg::IP_HDR_BYTES; i += 2)
            acc = acc + {hdr[i], hdr[i + 1]};
        while (acc[31:16] != 16'd0)
            acc = acc[15:0] + acc[31:16];
        {hdr[10], hdr[11]} = ~acc[15:0];
        if (bad_csum)
        begin
            k = 10 + $urandom_range(0, 1);
            hdr[k] = hdr[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        for (int i = 0; i < ihc_pkg::IP_HDR_BYTES; i++)
            frame_buf.push_back(hdr[i]);
        for (int i = 0; i < pay_len; i++)
            frame_buf.push_back(8'($urandom));
        emit_frame();
    endtask

    task automatic noise_frame(input int len, input int pattern);
        for (int i = 0; i < len; i++)
            frame_buf.push_back(pattern < 0 ? 8'($urandom) : 8'(pattern));
        emit_frame();
    endtask

    task automatic random_frame();
        int         r;
        int         pay;
        int         rx;
        logic [7:0] proto;
        logic [7:0] flg;
        logic [7:0] frg;
        r = $urandom_range(0, 99);
        pay = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
        rx = ihc_pkg::IP_HDR_BYTES + pay;
        if ($urandom_range(0, 99) < 85)
        begin
            case ($urandom_range(0, 2))
                0: proto = ihc_pkg::PROTO_ICMP;
                1: proto = ihc_pkg::PROTO_UDP;
                default: proto = ihc_pkg::PROTO_TCP;
            endcase
        end
        else
        begin
            proto = 8'($urandom);
        end
        flg = $urandom_range(0, 1) ? ihc_pkg::FLAG_DF : 8'd0;
        if (r < 60)
        begin
            build_frame(ihc_pkg::VER_IHL_IPV4, proto, flg, 8'd0, pay,
                        $urandom_range(0, 1) ? rx : $urandom_range(0, rx), 1'b0,
                        $urandom, $urandom);
        end
        else if (r < 67)
        begin
            build_frame(8'($urandom), proto, flg, 8'd0, pay, rx, 1'b0, $urandom, $urandom);
        end
        else if (r < 74)
        begin
            build_frame(ihc_pkg::VER_IHL_IPV4, proto, flg, 8'd0, pay,
                        $urandom_range(0, 1) ? rx + 1 : $urandom_range(rx + 1, 65535), 1'b0,
                        $urandom, $urandom);
        end
        else if (r < 81)
        begin
            build_frame(ihc_pkg::VER_IHL_IPV4, proto, flg, 8'd0, pay, rx, 1'b1,
                        $urandom, $urandom);
        end
        else if (r < 88)
        begin
            flg = 8'($urandom);
            frg = 8'($urandom);
            if ((flg & ~ihc_pkg::FLAG_DF) == 8'd0 && frg == 8'd0)
                frg = 8'd1 << $urandom_range(0, 7);
            build_frame(ihc_pkg::VER_IHL_IPV4, proto, flg, frg, pay, rx, 1'b0,
                        $urandom, $urandom);
        end
        else if (r < 94)
        begin
            noise_frame($urandom_range(1, MAC_BYTES + ihc_pkg::IP_HDR_BYTES), -1);
        end
        else
        begin
            noise_frame($urandom_range(1, 60), -1);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            case (traffic_phase())
                0: push <= pend_q.size() > 0 && $urandom_range(0, 99) >= 31;
                1: push <= pend_q.size() > 0 && $urandom_range(0, 99) >= 88;
                default: push <= pend_q.size() > 0;
            endcase
            if (pend_q.size() > 0)
                request <= pend_q[0];
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            classify_byte(request);
            void'(pend_q.pop_front());
            accepted_count++;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            case (traffic_phase())
                0: pop <= $urandom_range(0, 99) >= 88;
                1: pop <= $urandom_range(0, 99) >= 31;
                default: pop <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        ihc_pkg::out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("verdict transfer with no verdict expected");
                fail_count++;
            end
            else
            begin
                want = verdict_q.pop_front();
                check_field("accepted", want.accepted, result.accepted);
                check_field("drop_reason", want.drop_reason, result.drop_reason);
                check_field("proto_class", want.proto_class, result.proto_class);
                check_field("protocol_number", want.protocol_number, result.protocol_number);
                check_field("ip_total_length", want.ip_total_length, result.ip_total_length);
                check_field("received_length", want.received_length, result.received_length);
                check_field("source_address", want.source_address, result.source_address);
                check_field("dest_address", want.dest_address, result.dest_address);
                check_field("icmp_count", want.icmp_count, result.icmp_count);
            end
        end
    end

    initial
    begin
        build_frame(ihc_pkg::VER_IHL_IPV4, ihc_pkg::PROTO_ICMP, 8'd0, 8'd0, 1, 21, 1'b0,
                    32'h0, 32'h0);
        noise_frame(1, -1);
        noise_frame(MAC_BYTES, -1);
        noise_frame(MAC_BYTES + 1, -1);
        build_frame(ihc_pkg::VER_IHL_IPV4, ihc_pkg::PROTO_UDP, 8'd0, 8'd0, 0, 20, 1'b0,
                    $urandom, $urandom);
        build_frame(ihc_pkg::VER_IHL_IPV4, ihc_pkg::PROTO_UDP, ihc_pkg::FLAG_DF, 8'd0, 4, 20,
                    1'b0, 32'hFFFF_FFFF, 32'h0);
        build_frame(ihc_pkg::VER_IHL_IPV4, ihc_pkg::PROTO_TCP, 8'd0, 8'd0, 3, 23, 1'b0,
                    32'h0, 32'hFFFF_FFFF);
        build_frame(ihc_pkg::VER_IHL_IPV4, 8'hFF, 8'd0, 8'd0, 2, 22, 1'b0,
                    $urandom, $urandom);
        build_frame(ihc_pkg::VER_IHL_IPV4, 8'h00, ihc_pkg::FLAG_DF, 8'd0, 2, 22, 1'b0,
                    $urandom, $urandom);
        build_frame(8'h46, ihc_pkg::PROTO_TCP, 8'd0, 8'd0, 2, 22, 1'b0, $urandom, $urandom);
        build_frame(ihc_pkg::VER_IHL_IPV4, ihc_pkg::PROTO_TCP, 8'd0, 8'd0, 2, 23, 1'b0,
                    $urandom, $urandom);
        build_frame(ihc_pkg::VER_IHL_IPV4, ihc_pkg::PROTO_UDP, 8'd0, 8'd0, 2, 65535, 1'b0,
                    $urandom, $urandom);
        build_frame(ihc_pkg::VER_IHL_IPV4, ihc_pkg::PROTO_ICMP, 8'd0, 8'd0, 2, 22, 1'b1,
                    $urandom, $urandom);
        build_frame(ihc_pkg::VER_IHL_IPV4, ihc_pkg::PROTO_ICMP, 8'h20, 8'd0, 2, 22, 1'b0,
                    $urandom, $urandom);
        build_frame(ihc_pkg::VER_IHL_IPV4, ihc_pkg::PROTO_ICMP, 8'd0, 8'h01, 2, 22, 1'b0,
                    $urandom, $urandom);
        build_frame(ihc_pkg::VER_IHL_IPV4, ihc_pkg::PROTO_ICMP, 8'hFF, 8'hFF, 2, 22, 1'b0,
                    $urandom, $urandom);
        build_frame(ihc_pkg::VER_IHL_IPV4, ihc_pkg::PROTO_ICMP, ihc_pkg::FLAG_DF, 8'd0, 5, 0,
                    1'b0, $urandom, $urandom);
        noise_frame(40, 8'hFF);
        noise_frame(40, 8'h00);
        while (pend_q.size() < 1550)
            random_frame();
        phase_a = pend_q.size() / 3;
        phase_b = 2 * pend_q.size() / 3;
        total_items = pend_q.size();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_count < total_items)
            @(posedge clk);
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
